[rtl/foiir_pkg.sv]
// Shared constants and types for the fourth-order IIR low-pass unit.
// Used by the feedback lane and by the top level; depends on nothing.
package foiir_pkg;

  // Default sizes of the sample and of the internal accumulators.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 48;

  // Coefficient formats: feedback signed Q4.28, gain unsigned Q3.28.
  localparam int COEF_FRAC  = 28;
  localparam int GAIN_WIDTH = 31;
  localparam int COEF_WIDTH = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_WIDTH = 3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_1  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_2  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_3  = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_4  = 3'd4;

  // Control of one bit-serial feedback lane.
  typedef struct packed {
    logic clear;
    logic step;
  } lane_ctrl_t;

endpackage

[rtl/foiir_fb_lane.sv]
// One bit-serial feedback multiplier lane: coefficient magnitude times a
// serial operand, giving the product shifted right by the coefficient
// fraction. Depends on foiir_pkg.
module foiir_fb_lane #(
  parameter int ACC_WIDTH = foiir_pkg::ACC_WIDTH_DEF
) (
  input  logic                             clk,
  input  foiir_pkg::lane_ctrl_t            ctrl,
  input  logic [foiir_pkg::COEF_WIDTH-1:0] coef_mag,
  input  logic                             bit_in,
  output logic [ACC_WIDTH-1:0]             product
);

  localparam int CW = foiir_pkg::COEF_WIDTH;

  logic [CW:0]          acc_r, acc_nxt;
  logic [ACC_WIDTH-1:0] lo_r, lo_nxt;
  logic [CW:0]          sum;
  logic [CW+ACC_WIDTH:0] full;

  // Add the coefficient when the serial bit is set, then shift one place.
  always_comb begin
    sum     = acc_r + (bit_in ? {1'b0, coef_mag} : '0);
    acc_nxt = sum >> 1;
    lo_nxt  = {sum[0], lo_r[ACC_WIDTH-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.step) begin
      acc_r <= acc_nxt;
      lo_r  <= lo_nxt;
    end
  end

  // After all operand bits the full product sits in the accumulator and the
  // low shift register; the fraction bits are dropped (truncation).
  assign full    = {acc_r, lo_r};
  assign product = full[foiir_pkg::COEF_FRAC +: ACC_WIDTH];

endmodule

[rtl/fourth_order_iir_lowpass_unit.sv]
// Fourth-order IIR low-pass filter, transposed direct form II, bit-serial.
// Each sample runs a serial gain multiply over the sample bits (ST_MULX), then
// the four feedback lanes over the output bits (ST_MULFB); a new input sample
// is accepted only in ST_IDLE, after the previous result has been registered
// for output, and ST_FINISH waits while the output is still held.
// Reset (synchronous, rst_n low) clears the coefficients and all four delays.
module fourth_order_iir_lowpass_unit #(
  parameter int SAMPLE_WIDTH = foiir_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = foiir_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream; tdata: sample_in.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,
  // Result stream; tdata: sample_out.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [foiir_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [foiir_pkg::COEF_WIDTH-1:0]    cfg_data
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int GW      = foiir_pkg::GAIN_WIDTH;
  localparam int CW      = foiir_pkg::COEF_WIDTH;
  localparam int FRAC    = foiir_pkg::COEF_FRAC;
  localparam int CNT_W   = $clog2(ACC_WIDTH > SAMPLE_WIDTH ? ACC_WIDTH : SAMPLE_WIDTH);
  localparam int QW      = (ACC_WIDTH - FRAC + 1 > SAMPLE_WIDTH + 1) ?
                           ACC_WIDTH - FRAC + 1 : SAMPLE_WIDTH + 1;
  localparam logic signed [QW-1:0] SAT_MAX = QW'((2 ** (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [QW-1:0] SAT_MIN = -SAT_MAX - QW'(1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MULX   = 5'b00010,
    ST_YCALC  = 5'b00100,
    ST_MULFB  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  // Configuration registers.
  logic [GW-1:0]        gain_r;
  logic signed [CW-1:0] fb_r [4];

  // Datapath registers.
  logic signed [GW+1:0]     xacc_r;
  logic [SAMPLE_WIDTH-1:0]  xs_r;
  logic [ACC_WIDTH-1:0]     t1_r, t6_r, y_r, ym_r;
  logic [ACC_WIDTH-1:0]     base_r [4];
  logic [ACC_WIDTH-1:0]     delay_r [4];
  logic [3:0]               neg_r;
  logic [SAMPLE_WIDTH-1:0]  out_sample_r;

  logic                     in_acc, out_free, finish_go;
  logic signed [GW+1:0]     x_add, x_sum;
  logic [ACC_WIDTH-1:0]     t1_w, t4_w, y_w;
  logic [CW-1:0]            coef_mag [4];
  logic [ACC_WIDTH-1:0]     lane_prod [4];
  foiir_pkg::lane_ctrl_t    lane_ctrl;
  logic signed [QW-1:0]     q_w;
  logic [SAMPLE_WIDTH-1:0]  sat_w;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish_go = (state_r == ST_FINISH) && out_free;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_sample_r);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_MULX;
        end
      end
      ST_MULX: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SAMPLE_WIDTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_YCALC;
        end
      end
      ST_YCALC: begin
        cnt_nxt   = '0;
        state_nxt = ST_MULFB;
      end
      ST_MULFB: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACC_WIDTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers, plus the filter delays.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      gain_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        fb_r[i]    <= '0;
        delay_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          foiir_pkg::REG_GAIN: gain_r  <= cfg_data[GW-1:0];
          foiir_pkg::REG_FB_1: fb_r[0] <= cfg_data;
          foiir_pkg::REG_FB_2: fb_r[1] <= cfg_data;
          foiir_pkg::REG_FB_3: fb_r[2] <= cfg_data;
          foiir_pkg::REG_FB_4: fb_r[3] <= cfg_data;
          default: ;
        endcase
      end
      // Each delay takes its base sum plus the signed, truncated feedback term.
      if (finish_go) begin
        for (int i = 0; i < 4; i++) begin
          delay_r[i] <= base_r[i] + (neg_r[i] ? ~lane_prod[i] : lane_prod[i])
                        + ACC_WIDTH'(neg_r[i]);
        end
      end
    end
  end

  // Serial gain multiply: one sample bit a step, the sign bit weighs negative.
  always_comb begin
    x_add = '0;
    if (xs_r[0]) begin
      x_add = (cnt_r == CNT_W'(SAMPLE_WIDTH - 1)) ? -$signed({2'b00, gain_r})
                                                  : $signed({2'b00, gain_r});
    end
    x_sum = xacc_r + x_add;
  end

  // Feedforward terms and the full-precision output.
  assign t1_w = ACC_WIDTH'($signed({xacc_r, xs_r}));
  assign t4_w = {t1_r[ACC_WIDTH-3:0], 2'b00};
  assign y_w  = t1_w + delay_r[0];

  // Coefficient magnitudes for the unsigned lanes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      coef_mag[i] = fb_r[i][CW-1] ? (~fb_r[i] + CW'(1)) : fb_r[i];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          xs_r   <= in_tdata[SAMPLE_WIDTH-1:0];
          xacc_r <= '0;
        end
      end
      ST_MULX: begin
        xacc_r <= x_sum >>> 1;
        xs_r   <= {x_sum[0], xs_r[SAMPLE_WIDTH-1:1]};
      end
      ST_YCALC: begin
        t1_r <= t1_w;
        t6_r <= {t1_w[ACC_WIDTH-3:0], 2'b00} + {t1_w[ACC_WIDTH-2:0], 1'b0};
        y_r  <= y_w;
        ym_r <= y_w[ACC_WIDTH-1] ? (~y_w + ACC_WIDTH'(1)) : y_w;
        for (int i = 0; i < 4; i++) begin
          neg_r[i] <= y_w[ACC_WIDTH-1] ^ fb_r[i][CW-1];
        end
      end
      ST_MULFB: begin
        ym_r <= ym_r >> 1;
        // The old delays stay put until the end, so the bases form here.
        if (cnt_r == '0) begin
          base_r[0] <= t4_w + delay_r[1];
          base_r[1] <= t6_r + delay_r[2];
          base_r[2] <= t4_w + delay_r[3];
          base_r[3] <= t1_r;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_sample_r <= sat_w;
        end
      end
      default: ;
    endcase
  end

  // Four feedback lanes share the serial magnitude of the output.
  assign lane_ctrl.clear = (state_r == ST_YCALC);
  assign lane_ctrl.step  = (state_r == ST_MULFB);

  for (genvar i = 0; i < 4; i++) begin : g_lane
    foiir_fb_lane #(
      .ACC_WIDTH(ACC_WIDTH)
    ) u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .coef_mag(coef_mag[i]),
      .bit_in  (ym_r[0]),
      .product (lane_prod[i])
    );
  end

  // Round to nearest with ties upward, then saturate to the sample range.
  assign q_w = QW'($signed(y_r[ACC_WIDTH-1:FRAC]))
               + $signed({{(QW-1){1'b0}}, y_r[FRAC-1]});

  always_comb begin
    if (q_w > SAT_MAX) begin
      sat_w = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (q_w < SAT_MIN) begin
      sat_w = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      sat_w = q_w[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

[tb/sv/fourth_order_iir_lowpass_unit_tb.sv]
// Self-checking testbench for the fourth-order IIR low-pass unit: a queue-fed
// driver, a checking monitor and a bit-exact fixed-point predictor of the filter.
// Depends on foiir_pkg and the fourth_order_iir_lowpass_unit RTL only.
module fourth_order_iir_lowpass_unit_tb;

  localparam int SW             = foiir_pkg::SAMPLE_WIDTH_DEF;
  localparam int AW             = foiir_pkg::ACC_WIDTH_DEF;
  localparam int CFW            = foiir_pkg::COEF_WIDTH;
  localparam int FRAC           = foiir_pkg::COEF_FRAC;
  localparam int GW             = foiir_pkg::GAIN_WIDTH;
  localparam int IDXW           = foiir_pkg::CFG_IDX_WIDTH;
  localparam int TDW            = ((SW + 7) / 8) * 8;
  localparam int PW             = AW + CFW;
  localparam int RESULT_LATENCY = SW + AW + 3;
  localparam int LONG_HOLD      = 600;
  localparam int CYCLE_LIMIT    = 1500000;
  localparam int SAT_MAX        = 2 ** (SW - 1) - 1;
  localparam int SAT_MIN        = -(2 ** (SW - 1));
  localparam logic signed [AW:0] ROUND_HALF = (AW + 1)'(1) << (FRAC - 1);

  // Butterworth sections in Q4.28: cutoff at a quarter and a tenth of the sample rate.
  localparam logic [31:0] QUARTER_GAIN = 32'd25227833;
  localparam logic [31:0] QUARTER_FB2  = -32'sd130467417;
  localparam logic [31:0] QUARTER_FB4  = -32'sd4741912;
  localparam logic [31:0] TENTH_GAIN   = 32'd1294933;
  localparam logic [31:0] TENTH_FB1    = 32'sd636057813;
  localparam logic [31:0] TENTH_FB2    = -32'sd621159645;
  localparam logic [31:0] TENTH_FB3    = 32'sd283118875;
  localparam logic [31:0] TENTH_FB4    = -32'sd50304804;
  localparam logic [31:0] COEF_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_MIN     = 32'h8000_0000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [TDW-1:0]           in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [TDW-1:0]           out_tdata;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [IDXW-1:0]          cfg_index  = '0;
  logic [CFW-1:0]           cfg_data   = '0;

  fourth_order_iir_lowpass_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Mirror of the coefficient registers and of the four delay accumulators.
  logic [GW-1:0]         gain_reg    = '0;
  logic signed [CFW-1:0] fb_coef [4] = '{default: '0};
  logic [AW-1:0]         delay_acc [4] = '{default: '0};

  logic signed [SW-1:0] pending_samples [$];
  logic signed [SW-1:0] expected_samples [$];
  int                   send_idle_pct   = 0;
  int                   recv_stall_pct  = 0;
  logic                 long_hold_armed = 1'b0;
  int                   long_hold_count = 0;
  int                   mismatches      = 0;
  int                   cycle_count     = 0;

  // (coef * y) >> 28 on magnitudes, so the shift truncates toward zero, then signed.
  function automatic logic [AW-1:0] scaled_feedback(input logic signed [CFW-1:0] coef,
                                                    input logic [AW-1:0] y);
    logic [AW-1:0]         mag_y;
    logic [CFW-1:0]        mag_c;
    logic [PW-1:0]         prod;
    logic [AW-1:0]         r;
    logic                  neg;
    neg   = y[AW-1] ^ coef[CFW-1];
    mag_y = y[AW-1] ? -y : y;
    mag_c = coef[CFW-1] ? -coef : coef;
    prod  = PW'(mag_y) * PW'(mag_c);
    r     = prod[AW+FRAC-1:FRAC];
    return neg ? -r : r;
  endfunction

  // One sample through the transposed direct form II section; all sums wrap at AW bits.
  function automatic logic signed [SW-1:0] predict_filtered_sample(input logic signed [SW-1:0] x);
    logic [AW-1:0]     x_ext;
    logic [AW-1:0]     gain_ext;
    logic [AW-1:0]     tap1;
    logic [AW-1:0]     tap4;
    logic [AW-1:0]     tap6;
    logic [AW-1:0]     y;
    logic signed [AW:0] rounded;
    x_ext    = {{(AW - SW){x[SW-1]}}, x};
    gain_ext = {{(AW - GW){1'b0}}, gain_reg};
    tap1     = x_ext * gain_ext;
    tap4     = x_ext * (gain_ext << 2);
    tap6     = x_ext * (gain_ext * 6);
    y        = tap1 + delay_acc[0];
    delay_acc[0] = tap4 + scaled_feedback(fb_coef[0], y) + delay_acc[1];
    delay_acc[1] = tap6 + scaled_feedback(fb_coef[1], y) + delay_acc[2];
    delay_acc[2] = tap4 + scaled_feedback(fb_coef[2], y) + delay_acc[3];
    delay_acc[3] = tap1 + scaled_feedback(fb_coef[3], y);
    // Round to nearest with ties upward, then saturate.
    rounded = $signed({y[AW-1], y});
    rounded = (rounded + ROUND_HALF) >>> FRAC;
    if (rounded > SAT_MAX)
      return SW'(SAT_MAX);
    if (rounded < SAT_MIN)
      return SW'(SAT_MIN);
    return rounded[SW-1:0];
  endfunction

  // Audio-like stimulus: full-range noise, quiet passages, held steps, rails and ramps.
  function automatic logic signed [SW-1:0] next_sample(input logic signed [SW-1:0] prev);
    int kind;
    kind = $urandom_range(99);
    if (kind < 40)
      return SW'($urandom());
    if (kind < 65)
      return SW'(int'($urandom_range(512)) - 256);
    if (kind < 80)
      return prev;
    if (kind < 90)
      return $urandom_range(1) ? SW'(SAT_MAX) : SW'(SAT_MIN);
    return prev + SW'(int'($urandom_range(64)) - 32);
  endfunction

  // Driver: predicts each accepted sample and offers the next pending one.
  always @(posedge clk) begin
    if (in_tvalid && in_tready)
      expected_samples.push_back(predict_filtered_sample(in_tdata[SW-1:0]));
    if (!in_tvalid || in_tready) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= TDW'(pending_samples.pop_front());
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : result_check
    logic signed [SW-1:0] want;
    if (out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample_out %0d", $time, $signed(out_tdata[SW-1:0]));
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata[SW-1:0] !== want) begin
          $display("%0t: sample_out expected %0d, got %0d",
                   $time, want, $signed(out_tdata[SW-1:0]));
          mismatches++;
        end
      end
    end
    // One long hold-off so that the unit fills and back-pressures its input.
    if (long_hold_armed && long_hold_count < LONG_HOLD) begin
      long_hold_count++;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fourth_order_iir_lowpass_unit: mismatch");
      $finish;
    end
  end

  // Register write; called at a rising edge and returns at the accepting edge.
  task automatic cfg_write(input logic [IDXW-1:0] idx,
                           input logic [CFW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      foiir_pkg::REG_GAIN: gain_reg   = data[GW-1:0];
      foiir_pkg::REG_FB_1: fb_coef[0] = data;
      foiir_pkg::REG_FB_2: fb_coef[1] = data;
      foiir_pkg::REG_FB_3: fb_coef[2] = data;
      foiir_pkg::REG_FB_4: fb_coef[3] = data;
      default: ;
    endcase
  endtask

  // Loads all five coefficients plus one write to an unused index.
  task automatic load_filter(input logic [31:0] gain, input logic [31:0] fb1,
                             input logic [31:0] fb2, input logic [31:0] fb3,
                             input logic [31:0] fb4);
    @(posedge clk);
    cfg_write(foiir_pkg::REG_GAIN, gain);
    cfg_write(foiir_pkg::REG_FB_1, fb1);
    cfg_write(foiir_pkg::REG_FB_2, fb2);
    cfg_write(foiir_pkg::REG_FB_3, fb3);
    cfg_write(foiir_pkg::REG_FB_4, fb4);
    cfg_write(IDXW'($urandom_range(2 ** IDXW - 1, foiir_pkg::REG_FB_4 + 1)), $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Random gain up to unity with a random top bit; feedback within plus or minus one half.
  task automatic load_random_filter();
    logic [31:0] fb [4];
    for (int i = 0; i < 4; i++)
      fb[i] = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
    load_filter({1'($urandom_range(1)), 31'($urandom_range(32'h1000_0000))},
                fb[0], fb[1], fb[2], fb[3]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() > 0 || in_tvalid || expected_samples.size() > 0);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic queue_random(input int count);
    logic signed [SW-1:0] s;
    s = '0;
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      s = next_sample(s);
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Coefficients still at reset: every output is zero.
    @(negedge clk);
    pending_samples = '{16'sh7FFF, 16'sh8000};
    wait_drained();

    // Gain of one half without feedback; the top data bit must be dropped. The unit
    // impulses give exact half-way values that round upward.
    load_filter(32'h8800_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    @(negedge clk);
    pending_samples = '{0, 0, 0, 0, 1, 0, 0, 0, 0, -1, 0, 0, 0, 0};
    wait_drained();

    // Extreme coefficients: wrapping accumulators and saturation at both rails.
    load_filter(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    @(negedge clk);
    pending_samples = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, -1, 1, 16'sh5555};
    wait_drained();

    // Quarter-band low-pass, no idling, with the long receiver hold-off.
    load_filter(QUARTER_GAIN, 32'h0, QUARTER_FB2, 32'h0, QUARTER_FB4);
    set_idling(0, 0);
    long_hold_armed = 1'b1;
    queue_random(300);
    wait_drained();

    // Tenth-band low-pass with a mostly idle sender.
    load_filter(TENTH_GAIN, TENTH_FB1, TENTH_FB2, TENTH_FB3, TENTH_FB4);
    set_idling(88, 0);
    queue_random(250);
    wait_drained();

    // Random coefficients with a mostly stalled receiver.
    load_random_filter();
    set_idling(0, 88);
    queue_random(250);
    wait_drained();

    // Both sides idling; the sender pauses half-way until all results are back.
    load_random_filter();
    set_idling(23, 23);
    queue_random(125);
    wait_drained();
    queue_random(125);
    wait_drained();

    // Opposite extremes of the feedback coefficients, no idling.
    load_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    set_idling(0, 0);
    queue_random(150);
    wait_drained();

    load_random_filter();
    set_idling(23, 23);
    queue_random(250);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("fourth_order_iir_lowpass_unit: match");
    else
      $display("fourth_order_iir_lowpass_unit: mismatch");
    $finish;
  end

endmodule

[fourth_order_iir_lowpass_unit.f]
rtl/foiir_pkg.sv
rtl/foiir_fb_lane.sv
rtl/fourth_order_iir_lowpass_unit.sv
tb/sv/fourth_order_iir_lowpass_unit_tb.sv
